// ===== hw/rtl/rscc_pkg.sv =====
// Package for the row site coverage checker: field widths, action and
// result codes, sequencer state and the divider status struct.
// No dependencies.
package rscc_pkg;

  localparam int COORD_BITS = 32;
  localparam int FIELD_W    = 32;
  localparam int ROW_W      = 24;
  localparam int SITE_W     = 20;
  localparam int COUNT_W    = 31;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ACT_ROW_START = 2'd0,
    ACT_INST      = 2'd1,
    ACT_ROW_END   = 2'd2,
    ACT_FINISH    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_GAP      = 3'd0,
    KIND_OVERLAP  = 3'd1,
    KIND_OFF_GRID = 3'd2,
    KIND_ILLEGAL  = 3'd3,
    KIND_SUMMARY  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PREP  = 3'd1,
    ST_START = 3'd2,
    ST_DIV   = 3'd3,
    ST_EMIT  = 3'd4
  } state_t;

  typedef enum logic [1:0] {
    PH_SPAN  = 2'd0,
    PH_GRID  = 2'd1,
    PH_COVER = 2'd2
  } phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/rscc_if.sv =====
// Valid/ready channel interfaces for the row site coverage checker.
// Depends on rscc_pkg for widths and codes.
interface rscc_in_if;
  logic                            valid;
  logic                            ready;
  rscc_pkg::action_t               action;
  logic [rscc_pkg::ROW_W-1:0]      row_id;
  logic signed [rscc_pkg::FIELD_W-1:0] legal_lo;
  logic signed [rscc_pkg::FIELD_W-1:0] legal_hi;
  logic signed [rscc_pkg::FIELD_W-1:0] inst_lo;
  logic signed [rscc_pkg::FIELD_W-1:0] inst_hi;
  logic [rscc_pkg::FIELD_W-1:0]    inst_id;

  modport source (output valid, action, row_id, legal_lo, legal_hi, inst_lo, inst_hi,
                  inst_id, input ready);
  modport sink (input valid, action, row_id, legal_lo, legal_hi, inst_lo, inst_hi,
                inst_id, output ready);
endinterface

interface rscc_out_if;
  logic                            valid;
  logic                            ready;
  rscc_pkg::kind_t                 kind;
  logic [rscc_pkg::ROW_W-1:0]      issue_row;
  logic signed [rscc_pkg::FIELD_W-1:0] span_lo;
  logic signed [rscc_pkg::FIELD_W-1:0] span_hi;
  logic [rscc_pkg::COUNT_W-1:0]    site_count;
  logic [rscc_pkg::FIELD_W-1:0]    culprit_id;
  logic                            has_culprit;
  logic                            full_utility;
  logic                            last;

  modport source (output valid, kind, issue_row, span_lo, span_hi, site_count, culprit_id,
                  has_culprit, full_utility, last, input ready);
  modport sink (input valid, kind, issue_row, span_lo, span_hi, site_count, culprit_id,
                has_culprit, full_utility, last, output ready);
endinterface

// ===== hw/rtl/rscc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rscc_pkg for the divisor width and the status struct.
module rscc_div #(
  parameter int DW = rscc_pkg::COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [rscc_pkg::SITE_W-1:0] divisor,
  output rscc_pkg::div_stat_t         stat,
  output logic [DW-1:0]               quot,
  output logic [rscc_pkg::SITE_W-1:0] rem
);

  localparam int CNT_W = $clog2(DW + 1);
  localparam int SW    = rscc_pkg::SITE_W;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    num_r;
  logic [SW-1:0]    rem_r;
  logic [SW-1:0]    div_r;

  logic [SW:0]      trial;
  logic             ge;
  logic [SW-1:0]    rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[DW-1]};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? SW'(trial - {1'b0, div_r}) : trial[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      num_r <= {num_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = num_r;
  assign rem       = rem_r;

endmodule

// ===== hw/rtl/row_site_coverage_checker.sv =====
// Row site coverage checker: one instance per transaction, one item at a time.
// The sequencer takes a new item only from idle. A row start or a finish needs no division,
// a row end one and an instance three, all run on the single shared radix-2 divider; each
// issue is emitted as its own output item, and output stalls hold the sequencer. No
// transaction is taken until the last is loaded.
// Reset (synchronous, active low) clears row state, cursor and issue flag; width is 1.
module row_site_coverage_checker #(
  parameter int COORD_BITS = rscc_pkg::COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rscc_in_if.sink                     in_ch,
  rscc_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [rscc_pkg::SITE_W-1:0] cfg_wdata
);

  localparam int CW = COORD_BITS;
  localparam int FW = rscc_pkg::FIELD_W;
  localparam int NW = rscc_pkg::COUNT_W;
  localparam int QW = (CW > NW) ? CW : NW;
  localparam int SW = rscc_pkg::SITE_W;

  rscc_pkg::state_t   state_r, state_nxt;
  rscc_pkg::phase_t   phase_r, phase_nxt;
  logic [2:0]         pend_r, pend_nxt;
  logic               sum_r, sum_nxt;
  logic               issue_seen_r, issue_seen_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [SW-1:0]              site_w_r;
  logic [rscc_pkg::ROW_W-1:0] cur_row_r;
  logic signed [CW-1:0]       row_left_r, row_right_r, cursor_r;
  logic signed [CW-1:0]       lo_r, hi_r, g_lo_r, g_hi_r;
  logic [FW-1:0]              id_r;
  logic                       g_has_r;
  rscc_pkg::kind_t            g_kind_r;
  logic signed [CW:0]         diff_r;
  logic [NW-1:0]              cnt_a_r, cnt_c_r;

  rscc_pkg::kind_t            o_kind_r;
  logic [rscc_pkg::ROW_W-1:0] o_row_r;
  logic signed [FW-1:0]       o_lo_r, o_hi_r;
  logic [NW-1:0]              o_cnt_r;
  logic [FW-1:0]              o_id_r;
  logic                       o_has_r, o_full_r, o_last_r;

  logic signed [CW-1:0] legal_lo_c, legal_hi_c, inst_lo_c, inst_hi_c;
  logic signed [CW-1:0] opa, opb, ld_lo_c, ld_hi_c;
  logic signed [FW-1:0] ld_lo32, ld_hi32;
  logic [CW-1:0]        dividend, mag, clamp;
  logic [QW-1:0]        q_ext;
  logic [NW-1:0]        q_sat;
  logic [SW-1:0]        w_eff;
  logic                 in_ready, in_acc, slot_free, div_start, out_load;
  logic                 illegal, trail;
  logic [2:0]           rest;
  rscc_pkg::div_stat_t  div_stat;
  logic [CW-1:0]        div_quot;
  logic [SW-1:0]        div_rem;

  rscc_pkg::kind_t      ld_kind;
  logic [NW-1:0]        ld_cnt;
  logic [FW-1:0]        ld_id;
  logic                 ld_has, ld_full, ld_last, ld_coord;

  generate
    if (CW <= FW) begin : g_in_narrow
      assign legal_lo_c = in_ch.legal_lo[CW-1:0];
      assign legal_hi_c = in_ch.legal_hi[CW-1:0];
      assign inst_lo_c  = in_ch.inst_lo[CW-1:0];
      assign inst_hi_c  = in_ch.inst_hi[CW-1:0];
    end else begin : g_in_wide
      assign legal_lo_c = {{(CW-FW){in_ch.legal_lo[FW-1]}}, in_ch.legal_lo};
      assign legal_hi_c = {{(CW-FW){in_ch.legal_hi[FW-1]}}, in_ch.legal_hi};
      assign inst_lo_c  = {{(CW-FW){in_ch.inst_lo[FW-1]}}, in_ch.inst_lo};
      assign inst_hi_c  = {{(CW-FW){in_ch.inst_hi[FW-1]}}, in_ch.inst_hi};
    end
    if (CW < FW) begin : g_out_narrow
      assign ld_lo32 = {{(FW-CW){ld_lo_c[CW-1]}}, ld_lo_c};
      assign ld_hi32 = {{(FW-CW){ld_hi_c[CW-1]}}, ld_hi_c};
    end else begin : g_out_wide
      assign ld_lo32 = ld_lo_c[FW-1:0];
      assign ld_hi32 = ld_hi_c[FW-1:0];
    end
  endgenerate

  assign in_acc    = in_ch.valid && in_ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign w_eff     = (site_w_r == '0) ? SW'(1) : site_w_r;
  assign illegal   = (inst_lo_c < row_left_r) || (inst_hi_c > row_right_r);
  assign trail     = cursor_r < row_right_r;

  always_comb begin
    unique case (phase_r)
      rscc_pkg::PH_SPAN: begin
        opa = lo_r;
        opb = hi_r;
      end
      rscc_pkg::PH_GRID: begin
        opa = row_left_r;
        opb = lo_r;
      end
      rscc_pkg::PH_COVER: begin
        opa = g_lo_r;
        opb = g_hi_r;
      end
      default: begin
        opa = g_lo_r;
        opb = g_hi_r;
      end
    endcase
  end

  always_comb begin
    mag      = diff_r[CW] ? CW'(-diff_r) : diff_r[CW-1:0];
    clamp    = (diff_r[CW] || diff_r == '0) ? '0 : diff_r[CW-1:0];
    dividend = (phase_r == rscc_pkg::PH_GRID) ? mag : clamp;
    q_ext    = QW'(div_quot);
    q_sat    = (q_ext > QW'(rscc_pkg::COUNT_MAX)) ? rscc_pkg::COUNT_MAX : q_ext[NW-1:0];
  end

  rscc_div #(.DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (w_eff),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rscc_pkg::ST_IDLE;
      phase_r      <= rscc_pkg::PH_SPAN;
      pend_r       <= '0;
      sum_r        <= 1'b0;
      issue_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      pend_r       <= pend_nxt;
      sum_r        <= sum_nxt;
      issue_seen_r <= issue_seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    sum_nxt    = sum_r;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    ld_kind    = rscc_pkg::KIND_SUMMARY;
    ld_coord   = 1'b0;
    ld_cnt     = '0;
    ld_id      = '0;
    ld_has     = 1'b0;
    ld_full    = 1'b0;
    ld_last    = 1'b1;
    rest       = pend_r;
    unique case (state_r)
      rscc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          unique case (in_ch.action)
            rscc_pkg::ACT_ROW_START: ;
            rscc_pkg::ACT_INST: begin
              phase_nxt = rscc_pkg::PH_SPAN;
              pend_nxt  = {inst_lo_c != cursor_r, illegal, 1'b0};
              state_nxt = rscc_pkg::ST_PREP;
            end
            rscc_pkg::ACT_ROW_END: begin
              phase_nxt = rscc_pkg::PH_COVER;
              pend_nxt  = {trail, 2'b00};
              state_nxt = rscc_pkg::ST_PREP;
            end
            rscc_pkg::ACT_FINISH: begin
              sum_nxt   = 1'b1;
              state_nxt = rscc_pkg::ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      rscc_pkg::ST_PREP: begin
        state_nxt = rscc_pkg::ST_START;
      end
      rscc_pkg::ST_START: begin
        div_start = 1'b1;
        state_nxt = rscc_pkg::ST_DIV;
      end
      rscc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          unique case (phase_r)
            rscc_pkg::PH_SPAN: begin
              phase_nxt = rscc_pkg::PH_GRID;
              state_nxt = rscc_pkg::ST_PREP;
            end
            rscc_pkg::PH_GRID: begin
              pend_nxt[0] = div_rem != '0;
              phase_nxt   = rscc_pkg::PH_COVER;
              state_nxt   = rscc_pkg::ST_PREP;
            end
            default: begin
              state_nxt = rscc_pkg::ST_EMIT;
            end
          endcase
        end
      end
      rscc_pkg::ST_EMIT: begin
        if (sum_r) begin
          if (slot_free) begin
            out_load  = 1'b1;
            ld_full   = !issue_seen_r;
            sum_nxt   = 1'b0;
            state_nxt = rscc_pkg::ST_IDLE;
          end
        end else if (pend_r == '0) begin
          state_nxt = rscc_pkg::ST_IDLE;
        end else if (slot_free) begin
          out_load = 1'b1;
          ld_coord = 1'b1;
          priority if (pend_r[0]) begin
            ld_kind = rscc_pkg::KIND_OFF_GRID;
            ld_cnt  = cnt_a_r;
            ld_id   = id_r;
            ld_has  = 1'b1;
            rest    = {pend_r[2:1], 1'b0};
          end else if (pend_r[1]) begin
            ld_kind = rscc_pkg::KIND_ILLEGAL;
            ld_cnt  = cnt_a_r;
            ld_id   = id_r;
            ld_has  = 1'b1;
            rest    = {pend_r[2], 2'b00};
          end else begin
            ld_kind = g_kind_r;
            ld_cnt  = cnt_c_r;
            ld_id   = g_has_r ? id_r : '0;
            ld_has  = g_has_r;
            rest    = '0;
          end
          ld_last  = rest == '0;
          pend_nxt = rest;
          if (rest == '0) begin
            state_nxt = rscc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rscc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (!ld_coord) begin
      ld_lo_c = '0;
      ld_hi_c = '0;
    end else if (pend_r[0] || pend_r[1]) begin
      ld_lo_c = lo_r;
      ld_hi_c = hi_r;
    end else begin
      ld_lo_c = g_lo_r;
      ld_hi_c = g_hi_r;
    end
  end

  always_comb begin
    out_valid_nxt  = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    issue_seen_nxt = issue_seen_r;
    if (out_load) begin
      issue_seen_nxt = !sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_w_r    <= SW'(1);
      cur_row_r   <= '0;
      row_left_r  <= '0;
      row_right_r <= '0;
      cursor_r    <= '0;
    end else begin
      if (cfg_we) begin
        site_w_r <= cfg_wdata;
      end
      if (in_acc && in_ch.action == rscc_pkg::ACT_ROW_START) begin
        cur_row_r   <= in_ch.row_id;
        row_left_r  <= legal_lo_c;
        row_right_r <= legal_hi_c;
        cursor_r    <= legal_lo_c;
      end else if (in_acc && in_ch.action == rscc_pkg::ACT_INST) begin
        if (inst_hi_c > cursor_r) begin
          cursor_r <= inst_hi_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.action == rscc_pkg::ACT_INST) begin
      lo_r <= inst_lo_c;
      hi_r <= inst_hi_c;
      id_r <= in_ch.inst_id;
      if (inst_lo_c > cursor_r) begin
        g_kind_r <= rscc_pkg::KIND_GAP;
        g_lo_r   <= cursor_r;
        g_hi_r   <= inst_lo_c;
        g_has_r  <= 1'b0;
      end else begin
        g_kind_r <= rscc_pkg::KIND_OVERLAP;
        g_lo_r   <= inst_lo_c;
        g_hi_r   <= (cursor_r < inst_hi_c) ? cursor_r : inst_hi_c;
        g_has_r  <= 1'b1;
      end
    end else if (in_acc && in_ch.action == rscc_pkg::ACT_ROW_END) begin
      g_kind_r <= rscc_pkg::KIND_GAP;
      g_lo_r   <= cursor_r;
      g_hi_r   <= row_right_r;
      g_has_r  <= 1'b0;
    end
    if (state_r == rscc_pkg::ST_PREP) begin
      diff_r <= {opb[CW-1], opb} - {opa[CW-1], opa};
    end
    if (state_r == rscc_pkg::ST_DIV && div_stat.done) begin
      if (phase_r == rscc_pkg::PH_SPAN) begin
        cnt_a_r <= q_sat;
      end
      if (phase_r == rscc_pkg::PH_COVER) begin
        cnt_c_r <= q_sat;
      end
    end
    if (out_load) begin
      o_kind_r <= ld_kind;
      o_row_r  <= sum_r ? '0 : cur_row_r;
      o_lo_r   <= ld_lo32;
      o_hi_r   <= ld_hi32;
      o_cnt_r  <= ld_cnt;
      o_id_r   <= ld_id;
      o_has_r  <= ld_has;
      o_full_r <= ld_full;
      o_last_r <= ld_last;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = o_kind_r;
  assign out_ch.issue_row    = o_row_r;
  assign out_ch.span_lo      = o_lo_r;
  assign out_ch.span_hi      = o_hi_r;
  assign out_ch.site_count   = o_cnt_r;
  assign out_ch.culprit_id   = o_id_r;
  assign out_ch.has_culprit  = o_has_r;
  assign out_ch.full_utility = o_full_r;
  assign out_ch.last         = o_last_r;

`ifndef SYNTH
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rscc_pkg::ST_DIV |-> div_stat.busy || div_stat.done)
    else $error("divider idle while sequencer waits on it");

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rscc_pkg::ST_IDLE |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_gap_no_culprit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_kind_r == rscc_pkg::KIND_GAP |-> !o_has_r && o_id_r == '0)
    else $error("gap names a culprit");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_kind_r == rscc_pkg::KIND_SUMMARY |-> o_last_r && !o_has_r)
    else $error("summary not marked last");

  a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && sum_r |=> !issue_seen_r)
    else $error("issue flag not cleared by finish");
`endif

endmodule
